### sv/sbdt_pkg.sv
package sbdt_pkg;

    localparam int VALUE_W     = 64;
    localparam int NUM_DIGITS  = 20;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int CHAR_W      = 6;
    localparam int DIGIT_CNT_W = 5;
    localparam int BIT_CNT_W   = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [BIT_CNT_W-1:0]   BIT_LAST   = BIT_CNT_W'(VALUE_W - 1);
    localparam logic [DIGIT_CNT_W-1:0] DIGITS_ALL = DIGIT_CNT_W'(NUM_DIGITS);
    localparam logic [CHAR_W-1:0]      CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0]      CHAR_ZERO  = 6'd48;

    // Classified request: sign and unsigned magnitude.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } item_t;

    // Handshake between a producer and the queue or the queue and a consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### sv/sbdt_front.sv
module sbdt_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic signed [sbdt_pkg::VALUE_W-1:0] value,
    input  sbdt_pkg::q_stat_t              q_stat,
    output logic                           q_push,
    output sbdt_pkg::item_t                q_item
);
    import sbdt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    assign q_push = valid_reg && !q_stat.full;
    assign full   = valid_reg && q_stat.full;
    assign take   = push && !full;
    assign q_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (q_push)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next    = 1'b1;
            item_next.neg = value[VALUE_W-1];
            // The unsigned negation also gives the most negative value exactly.
            item_next.mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

### sv/sbdt_queue.sv
module sbdt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sbdt_pkg::item_t   wr_item,
    input  logic              pop,
    output sbdt_pkg::item_t   rd_item,
    output sbdt_pkg::q_stat_t stat
);
    import sbdt_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_item    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### sv/sbdt_back.sv
module sbdt_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbdt_pkg::q_stat_t             q_stat,
    input  sbdt_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [sbdt_pkg::CHAR_W-1:0]   character,
    output logic                          last_char
);
    import sbdt_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SKIP  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [VALUE_W-1:0]     mag_reg;
    logic [VALUE_W-1:0]     mag_next;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;
    logic [DIGIT_CNT_W-1:0] rem_reg;
    logic [DIGIT_CNT_W-1:0] rem_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CHAR_W-1:0]      char_reg;
    logic [CHAR_W-1:0]      char_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   slot_free;
    logic [3:0]             top_digit;

    assign empty     = !out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;
    assign slot_free = !out_valid_reg || pop;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign q_pop     = (state_reg == ST_IDLE) && !q_stat.empty;

    // Add-3 correction on every BCD digit before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !pop;
        char_next      = char_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    neg_next     = q_item.neg;
                    mag_next     = q_item.mag;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_LAST)
                begin
                    rem_next   = DIGITS_ALL;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, keeping at least one digit.
                if (top_digit == 4'd0 && rem_reg != DIGIT_CNT_W'(1))
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    rem_next = rem_reg - DIGIT_CNT_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + {2'b00, top_digit};
                    last_next      = (rem_reg == DIGIT_CNT_W'(1));
                    bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
                    rem_next       = rem_reg - DIGIT_CNT_W'(1);
                    if (rem_reg == DIGIT_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        rem_reg     <= rem_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

endmodule

### sv/signed_binary_to_decimal_text_top.sv
// With the block idle, a request that is taken passes the input register and the queue, then
// the shift-and-add-3 conversion over all 64 bits, then the dropping of leading zeros, 1 to 19
// of them, before the first character appears. The converter takes a new number from the
// queue only once the last character of the previous one is emitted; the leading-zero drops
// and the characters emitted together always cover all 20 digits.
// Reset (rst_n, asynchronous, active low) empties the input stage, the queue and the output
// register; no state is kept between numbers.
module signed_binary_to_decimal_text_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sbdt_pkg::VALUE_W-1:0] value,
    output logic                                empty,
    input  logic                                pop,
    output logic [sbdt_pkg::CHAR_W-1:0]         character,
    output logic                                last_char
);
    import sbdt_pkg::*;

    q_stat_t q_stat;
    item_t   wr_item;
    item_t   rd_item;
    logic    q_push;
    logic    q_pop;

    sbdt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .value  (value),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_item (wr_item)
    );

    sbdt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (wr_item),
        .pop     (q_pop),
        .rd_item (rd_item),
        .stat    (q_stat)
    );

    sbdt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_item    (rd_item),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last_char (last_char)
    );

endmodule

### sv/sbdt_checker.sv
module sbdt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                push,
    input logic                                full,
    input logic signed [sbdt_pkg::VALUE_W-1:0] value,
    input logic                                empty,
    input logic                                pop,
    input logic [sbdt_pkg::CHAR_W-1:0]         character,
    input logic                                last_char
);
    import sbdt_pkg::*;

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(character) && $stable(last_char)))
        else $error("result changed while waiting");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((character == CHAR_MINUS) ||
                    ((character >= CHAR_ZERO) && (character <= 6'd57))))
        else $error("result is not a minus sign or digit");

    // A minus sign always has digits after it.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && character == CHAR_MINUS) |-> !last_char)
        else $error("minus sign marked as last");

    // A minus sign is never followed directly by a zero digit.
    a_no_minus_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && character == CHAR_MINUS) |=>
        (empty || character != CHAR_ZERO))
        else $error("zero digit after minus sign");

    // The value port is watched only when a request is taken.
    a_no_x_request: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> !$isunknown(value))
        else $error("unknown value accepted");

endmodule

bind signed_binary_to_decimal_text_top sbdt_checker u_sbdt_checker (.*);
